// ===== hw/rtl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

	// Pattern capacity and derived widths
	localparam int MAX_PATTERN = 32;
	localparam int LIVE_W      = MAX_PATTERN + 1;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CLOSE_LVLS  = $clog2(LIVE_W);

	// Special pattern bytes
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;

	// Request function codes on the input port
	localparam logic [1:0] FUNC_CLEAR   = 2'd0;
	localparam logic [1:0] FUNC_APPEND  = 2'd1;
	localparam logic [1:0] FUNC_SUBJECT = 2'd2;
	localparam logic [1:0] FUNC_END     = 2'd3;

	// Queue between front and back (depth is a power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_APPEND,
		OP_SUBJECT,
		OP_END
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_value;
	} req_t;

	// Head of queue as seen by the back end
	typedef struct packed {
		logic valid;
		req_t req;
	} q_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wgm_front.sv =====
// ----------------------------------------------------------------------------
// wgm_front
// Accepts requests, decodes the function code and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_front import wgm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] char_value,
	output q_head_t         head,
	input  wire logic       pop
);

	req_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	req_t              dec_req;

	always_comb begin
		dec_req.char_value = char_value;
		case (func)
			FUNC_CLEAR:   dec_req.op = OP_CLEAR;
			FUNC_APPEND:  dec_req.op = OP_APPEND;
			FUNC_SUBJECT: dec_req.op = OP_SUBJECT;
			FUNC_END:     dec_req.op = OP_END;
			default:      dec_req.op = OP_END;
		endcase
	end

	assign in_stall   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = in_valid & ~in_stall;
	assign head.valid = (count_q != '0);
	assign head.req   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/wgm_back.sv =====
// ----------------------------------------------------------------------------
// wgm_back
// Pattern store, live position vector with star closure, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wgm_back import wgm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_head_t  head,
	output logic          pop,
	output logic          out_valid,
	input  wire logic     out_stall,
	output logic          matched,
	output logic          pattern_overflow
);

	// Positions reachable from v through runs of stars (log-depth prefix).
	// prop[j] set means position j-1 holds a star.
	function automatic logic [LIVE_W-1:0] star_close(
		input logic [LIVE_W-1:0] v,
		input logic [LIVE_W-1:0] prop
	);
		logic [LIVE_W-1:0] a;
		logic [LIVE_W-1:0] b;
		logic [LIVE_W-1:0] a_n;
		logic [LIVE_W-1:0] b_n;
		a = v;
		b = prop;
		for (int lv = 0; lv < CLOSE_LVLS; lv++) begin
			a_n = a;
			b_n = b;
			for (int j = 0; j < LIVE_W; j++) begin
				if (j >= (1 << lv)) begin
					a_n[j] = a[j] | (b[j] & a[j - (1 << lv)]);
					b_n[j] = b[j] & b[j - (1 << lv)];
				end
			end
			a = a_n;
			b = b_n;
		end
		return a;
	endfunction

	logic [7:0]             pat_q [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] used_q;
	logic [MAX_PATTERN-1:0] star_q;
	logic [MAX_PATTERN-1:0] any_q;
	logic [LIVE_W-1:0]      start_q;   // closure of position 0
	logic [LIVE_W-1:0]      live_q;
	logic [LEN_W-1:0]       len_q;
	logic                   open_q;
	logic                   ovf_q;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   ovf_out_q;

	logic [LIVE_W-1:0]      live_base;
	logic [MAX_PATTERN-1:0] eq;
	logic [MAX_PATTERN-1:0] advance;
	logic [MAX_PATTERN-1:0] hold;
	logic [LIVE_W-1:0]      live_next;
	logic [LEN_W-1:0]       len_inc;
	logic                   room;
	logic                   in_star;
	logic                   in_any;
	logic                   out_free;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign pop       = head.valid & ((head.req.op != OP_END) | out_free);
	assign live_base = open_q ? live_q : start_q;
	assign room      = (len_q < LEN_W'(MAX_PATTERN));
	assign len_inc   = len_q + 1'b1;
	assign in_star   = (head.req.char_value == STAR_BYTE);
	assign in_any    = (head.req.char_value == ANY_BYTE);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			eq[i] = (pat_q[i] == head.req.char_value);
		end
		advance   = live_base[MAX_PATTERN-1:0] & used_q & ~star_q & (any_q | eq);
		hold      = live_base[MAX_PATTERN-1:0] & star_q;
		live_next = star_close({advance, 1'b0} | {1'b0, hold}, {star_q, 1'b0});
	end

	// pattern bytes: no reset, only entries below len_q are used
	always_ff @(posedge clk) begin
		if (pop && head.req.op == OP_APPEND && room) begin
			pat_q[len_q[IDX_W-1:0]] <= head.req.char_value;
		end
	end

	// result payload loads only when the output register is free
	always_ff @(posedge clk) begin
		if (pop && head.req.op == OP_END) begin
			matched_q <= live_base[len_q];
			ovf_out_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			star_q      <= '0;
			any_q       <= '0;
			start_q     <= LIVE_W'(1);
			live_q      <= '0;
			len_q       <= '0;
			open_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.req.op)
					OP_CLEAR: begin
						used_q  <= '0;
						star_q  <= '0;
						any_q   <= '0;
						start_q <= LIVE_W'(1);
						len_q   <= '0;
						ovf_q   <= 1'b0;
						open_q  <= 1'b0;
						live_q  <= '0;
					end
					OP_APPEND: begin
						open_q <= 1'b0;
						live_q <= '0;
						if (room) begin
							used_q[len_q[IDX_W-1:0]] <= 1'b1;
							star_q[len_q[IDX_W-1:0]] <= in_star;
							any_q[len_q[IDX_W-1:0]]  <= in_any;
							start_q[len_inc]         <= start_q[len_q] & in_star;
							len_q                    <= len_inc;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					OP_SUBJECT: begin
						open_q <= 1'b1;
						live_q <= live_next;
					end
					OP_END: begin
						open_q      <= 1'b0;
						live_q      <= '0;
						out_valid_q <= 1'b1;
					end
					default: begin
						open_q <= open_q;
					end
				endcase
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = ovf_out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Whole-string glob match ('*' any run, '?' one byte) against a stored pattern.
// ----------------------------------------------------------------------------
// Throughput: one request per clock unless an end-of-subject request is held
//   by out_stall; the live-position vector is updated by a parallel compare
//   plus log-depth star closure. Result: an end-of-subject request passes the
//   queue, then the result register, before out_valid rises.
// Reset (arst_n low, asynchronous): queue empty, pattern length zero, no open
//   subject, overflow clear, no result pending. Pattern bytes are not cleared.
`default_nettype none

module wildcard_glob_matcher import wgm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] func,
	input  wire logic [7:0] char_value,
	// result channel
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            matched,
	output logic            pattern_overflow
);

	// Front: decode and queue. Stalls only when the queue is full, so input
	// keeps flowing while a result waits on out_stall.
	q_head_t head;
	logic    pop;

	wgm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.char_value (char_value),
		.head       (head),
		.pop        (pop)
	);

	// Back: executes one request per cycle. Only end-of-subject requests wait
	// for the result register; pattern and subject bytes never block.
	wgm_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

endmodule

`default_nettype wire

// ===== tb/tb_wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_wildcard_glob_matcher
// Self-checking testbench for the whole-string glob matcher.
// Requests (clear, append, subject byte, end of subject) go in with random
// gaps and bursts. A local copy of the live-position state machine predicts
// each verdict, and every verdict is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wildcard_glob_matcher import wgm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         RANDOM_ITEMS = 1100;
	localparam int         STALL_LIMIT  = 4000;  // cycles with no handshake at all
	localparam int         LONG_HOLD    = 300;   // receiver hold-off, fills the queue
	localparam int         DRAIN_CYCLES = 10;    // margin after the last verdict is checked
	localparam logic [7:0] LETTER_A     = 8'h61;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	// DUT hookup; every input has a known value from time zero
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic [1:0] func       = FUNC_CLEAR;
	logic [7:0] char_value = 8'h00;
	logic       out_stall  = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic       matched;
	logic       pattern_overflow;

	wildcard_glob_matcher DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.char_value       (char_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predicted matcher state (mirrors the block, updated on each accept)
	// ------------------------------------------------------------------
	logic [7:0]        glob_bytes [MAX_PATTERN];
	logic [LEN_W-1:0]  glob_len   = '0;
	logic [LIVE_W-1:0] live_set   = '0;
	logic              subj_open  = 1'b0;
	logic              ovf_flag   = 1'b0;

	verdict_t   pending_verdicts [$];   // verdicts predicted, not yet seen
	logic [7:0] plan_bytes [$];         // stimulus-side view of the stored pattern

	int  errors            = 0;
	int  items_sent        = 0;
	int  verdicts_checked  = 0;
	int  match_seen        = 0;
	int  overflow_seen     = 0;
	int  burst_left        = 0;
	bit  long_hold_pending = 1'b0;

	// A star at a live position also makes the next position live. Walking
	// upward lets a run of stars propagate in one pass.
	function automatic logic [LIVE_W-1:0] close_stars(input logic [LIVE_W-1:0] v);
		for (int i = 0; i < MAX_PATTERN; i++)
			if (i < glob_len && v[i] && glob_bytes[i] == STAR_BYTE)
				v[i + 1] = 1'b1;
		return v;
	endfunction

	// First subject byte or a bare end item: start from position zero.
	task automatic open_subject();
		if (!subj_open) begin
			live_set  = close_stars({{(LIVE_W - 1){1'b0}}, 1'b1});
			subj_open = 1'b1;
		end
	endtask

	// Apply one accepted request to the predicted state.
	task automatic glob_step(input op_t op, input logic [7:0] ch);
		logic [LIVE_W-1:0] nxt;
		verdict_t          v;
		case (op)
			OP_CLEAR: begin
				glob_len  = '0;
				ovf_flag  = 1'b0;
				subj_open = 1'b0;
				live_set  = '0;
			end
			OP_APPEND: begin
				// appending abandons any subject in flight
				subj_open = 1'b0;
				live_set  = '0;
				if (glob_len < MAX_PATTERN) begin
					glob_bytes[glob_len] = ch;
					glob_len++;
				end else begin
					ovf_flag = 1'b1;
				end
			end
			OP_SUBJECT: begin
				open_subject();
				nxt = '0;
				for (int i = 0; i < MAX_PATTERN; i++) begin
					if (i < glob_len && live_set[i]) begin
						if (glob_bytes[i] == STAR_BYTE)
							nxt[i] = 1'b1;        // star swallows the byte, stays put
						else if (glob_bytes[i] == ANY_BYTE || glob_bytes[i] == ch)
							nxt[i + 1] = 1'b1;
					end
				end
				live_set = close_stars(nxt);
			end
			default: begin
				open_subject();
				v.matched  = live_set[glob_len];
				v.overflow = ovf_flag;
				pending_verdicts = {pending_verdicts, v};
				subj_open = 1'b0;
				live_set  = '0;
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Sender: one request, held until accepted. Works in bursts with idle
	// gaps; long bursts give stretches with no idling at all.
	// ------------------------------------------------------------------
	task automatic send_req(input op_t op, input logic [7:0] ch);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 8);
		end
		burst_left--;
		in_valid   <= 1'b1;
		func       <= op;
		char_value <= ch;
		// in_stall read here is the value before this edge's updates
		@(posedge clk);
		while (in_stall) @(posedge clk);
		glob_step(op, ch);
		items_sent++;
	endtask

	// Pattern bytes lean on wildcards and a small alphabet so subjects hit.
	function automatic logic [7:0] rand_pattern_byte();
		case ($urandom_range(0, 9))
			0, 1:    return STAR_BYTE;
			2:       return ANY_BYTE;
			3, 4, 5, 6, 7: return LETTER_A + 8'($urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_subject_byte();
		if ($urandom_range(0, 7) != 0)
			return LETTER_A + 8'($urandom_range(0, 2));
		return 8'($urandom_range(0, 255));
	endfunction

	// Clear, then append n bytes. Bytes past capacity are dropped by the
	// block, so the plan keeps only the stored prefix.
	task automatic load_pattern(input int n);
		logic [7:0] b;
		send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
		plan_bytes.delete();
		repeat (n) begin
			b = rand_pattern_byte();
			send_req(OP_APPEND, b);
			if (plan_bytes.size() < MAX_PATTERN)
				plan_bytes = {plan_bytes, b};
		end
	endtask

	// Subject built to match the plan; corrupt = one byte changed, dropped
	// or inserted, which usually breaks the match.
	task automatic send_subject(input bit corrupt);
		logic [7:0] text [$];
		int         idx;
		foreach (plan_bytes[k]) begin
			if (plan_bytes[k] == STAR_BYTE)
				repeat ($urandom_range(0, 3)) text = {text, rand_subject_byte()};
			else if (plan_bytes[k] == ANY_BYTE)
				text = {text, 8'($urandom_range(0, 255))};
			else
				text = {text, plan_bytes[k]};
		end
		if (corrupt) begin
			if (text.size() == 0) begin
				text = {text, rand_subject_byte()};
			end else begin
				idx = $urandom_range(0, text.size() - 1);
				case ($urandom_range(0, 2))
					0:       text[idx] = rand_subject_byte();
					1:       text.delete(idx);
					default: text.insert(idx, rand_subject_byte());
				endcase
			end
		end
		foreach (text[k]) send_req(OP_SUBJECT, text[k]);
		send_req(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty pattern after reset: matches the empty subject, nothing else.
	task automatic test_empty_pattern();
		send_req(OP_END, 8'hFF);
		send_req(OP_SUBJECT, 8'hFF);
		send_req(OP_END, 8'h00);
	endtask

	// "*?<nul>": star over nothing, any-byte, and a zero byte as a literal.
	task automatic test_wildcards();
		send_req(OP_CLEAR, 8'h00);
		send_req(OP_APPEND, STAR_BYTE);
		send_req(OP_APPEND, ANY_BYTE);
		send_req(OP_APPEND, 8'h00);
		send_req(OP_SUBJECT, LETTER_A);
		send_req(OP_SUBJECT, 8'h00);
		send_req(OP_END, 8'h00);
		send_req(OP_SUBJECT, 8'h00);   // too short for '?' plus the zero byte
		send_req(OP_END, 8'hFF);
	endtask

	// Append and clear arriving in the middle of a subject.
	task automatic test_abandon();
		send_req(OP_SUBJECT, LETTER_A + 8'd25);
		send_req(OP_APPEND, 8'hFF);            // subject dropped, pattern grows
		send_req(OP_END, 8'h00);               // empty subject vs 4-byte pattern
		send_req(OP_SUBJECT, LETTER_A + 8'd16);
		send_req(OP_SUBJECT, 8'h00);
		send_req(OP_SUBJECT, 8'hFF);
		send_req(OP_END, 8'h00);
		send_req(OP_SUBJECT, LETTER_A + 8'd25);
		send_req(OP_CLEAR, 8'hFF);             // empty pattern, subject dropped
		send_req(OP_END, 8'h00);
	endtask

	// Fill the store, overrun it, match against the kept prefix, then
	// check that clear drops the overflow flag.
	task automatic test_pattern_full();
		load_pattern(MAX_PATTERN);
		send_subject(1'b0);
		send_req(OP_APPEND, 8'($urandom_range(0, 255)));
		send_req(OP_APPEND, 8'($urandom_range(0, 255)));
		send_subject(1'b0);
		send_subject(1'b1);
		send_req(OP_CLEAR, 8'h00);
		plan_bytes.delete();
		send_subject(1'b0);
	endtask

	// Mostly well-formed pattern/subject sequences, some cut short, some noise.
	task automatic test_random();
		int start;
		int r;
		int len;
		bit hold_issued;
		logic [7:0] b;
		start       = items_sent;
		hold_issued = 1'b0;
		while (items_sent - start < RANDOM_ITEMS) begin
			if (!hold_issued && items_sent - start > 400) begin
				long_hold_pending = 1'b1;    // receiver holds off while we keep sending
				hold_issued       = 1'b1;
			end
			r = $urandom_range(0, 19);
			if (r < 16) begin
				// small patterns dominate; a few fill or overrun the store
				case ($urandom_range(0, 19))
					0:       len = 0;
					15, 16, 17: len = $urandom_range(9, MAX_PATTERN - 1);
					18:      len = MAX_PATTERN;
					19:      len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
					default: len = $urandom_range(1, 8);
				endcase
				load_pattern(len);
				repeat ($urandom_range(1, 4)) send_subject($urandom_range(0, 3) == 0);
			end else if (r < 18) begin
				// subject cut off by an append or a clear
				repeat ($urandom_range(0, 4)) send_req(OP_SUBJECT, rand_subject_byte());
				if ($urandom_range(0, 1)) begin
					b = rand_pattern_byte();
					send_req(OP_APPEND, b);
					if (plan_bytes.size() < MAX_PATTERN)
						plan_bytes = {plan_bytes, b};
				end else begin
					send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
					plan_bytes.delete();
				end
				send_subject($urandom_range(0, 3) == 0);
			end else begin
				// raw noise; the plan may drift, which only changes hit rates
				repeat ($urandom_range(1, 6))
					send_req(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: stall pattern in phases (never, light, heavy, toggling),
	// plus one long hold-off on request from the random test.
	// ------------------------------------------------------------------
	initial begin : result_backpressure
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(posedge clk);
				if (long_hold_pending) begin
					long_hold_pending = 1'b0;
					out_stall <= 1'b1;
					for (int k = 1; k < LONG_HOLD; k++) @(posedge clk);
				end
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 3) == 0);
					2:       out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Verdict check: each accepted result against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				$display("[%0t] result with no request pending: expected none,",
				         $time);
				$display("    got matched=%0b overflow=%0b", matched, pattern_overflow);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				if (want.matched)  match_seen++;
				if (want.overflow) overflow_seen++;
				if (matched !== want.matched) begin
					errors++;
					$display("[%0t] matched: expected %0b, got %0b",
					         $time, want.matched, matched);
				end
				if (pattern_overflow !== want.overflow) begin
					errors++;
					$display("[%0t] pattern_overflow: expected %0b, got %0b",
					         $time, want.overflow, pattern_overflow);
				end
			end
		end
	end

	// Watchdog: too long without any handshake on either side ends the run.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] timeout: no handshake for %0d cycles, %0d verdicts outstanding",
		         $time, STALL_LIMIT, pending_verdicts.size());
		$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		foreach (glob_bytes[k]) glob_bytes[k] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pattern();
		test_wildcards();
		test_abandon();
		test_pattern_full();
		test_random();

		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d requests sent, %0d verdicts checked",
		         items_sent, verdicts_checked);
		$display("         %0d matches, %0d with dropped pattern bytes, %0d errors",
		         match_seen, overflow_seen, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/wgm_pkg.sv
hw/rtl/wgm_front.sv
hw/rtl/wgm_back.sv
hw/rtl/wildcard_glob_matcher.sv
tb/tb_wildcard_glob_matcher.sv
